>>> hdl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg: shared types and helpers for the infix expression evaluator
// Token classes, operator codes, error codes, decimal scale table and
// saturation helper used by the front end and the execution engine.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int VALUE_STACK_DEPTH_DEF    = 16;
  localparam int OPERATOR_STACK_DEPTH_DEF = 16;
  localparam int FRACTION_BITS_DEF        = 16;
  localparam int MAX_FRACTION_DIGITS_DEF  = 4;

  // Accumulator width for up to seven decimal fraction digits.
  localparam int FRAC_ACC_W = 24;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_DIV0      = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
  localparam logic [2:0] ERR_MALFORMED = 3'd3;
  localparam logic [2:0] ERR_SAT       = 3'd4;

  typedef enum logic [3:0] {
    TK_DIGIT, TK_POINT, TK_ADD, TK_SUB, TK_MUL, TK_DIV,
    TK_LPAREN, TK_RPAREN, TK_EQUALS, TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
  } tok_t;

  typedef enum logic [2:0] {
    OP_PAREN = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4
  } op_code_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } sat_res_t;

  function automatic tok_t classify(input logic [7:0] c);
    tok_t t;
    t.digit = 4'(c - CH_ZERO);
    if (c >= CH_ZERO && c <= CH_NINE) t.kind = TK_DIGIT;
    else if (c == CH_POINT)  t.kind = TK_POINT;
    else if (c == CH_ADD)    t.kind = TK_ADD;
    else if (c == CH_SUB)    t.kind = TK_SUB;
    else if (c == CH_MUL)    t.kind = TK_MUL;
    else if (c == CH_DIV)    t.kind = TK_DIV;
    else if (c == CH_LPAREN) t.kind = TK_LPAREN;
    else if (c == CH_RPAREN) t.kind = TK_RPAREN;
    else if (c == CH_EQUALS) t.kind = TK_EQUALS;
    else                     t.kind = TK_OTHER;
    return t;
  endfunction

  function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [2:0] n);
    logic [FRAC_ACC_W-1:0] p;
    unique case (n)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      3'd7: p = 24'd10000000;
      default: p = 24'd1;
    endcase
    return p;
  endfunction

  // Turns a sign and a magnitude into a saturated signed 32-bit value.
  function automatic sat_res_t from_mag(input logic neg, input logic [63:0] mag);
    sat_res_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.sat   = 1'b1;
        r.value = 32'sh8000_0000;
      end else begin
        r.value = 32'(-mag);
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        r.sat   = 1'b1;
        r.value = 32'sh7FFF_FFFF;
      end else begin
        r.value = mag[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

>>> hdl/iee_front.sv
// ----------------------------------------------------------------------------
// iee_front: character intake and token queue
// Classifies each accepted character and holds the tokens in a short queue
// until the execution engine takes them.
// ----------------------------------------------------------------------------
module iee_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    char_code,
  output logic          tok_valid,
  output iee_pkg::tok_t tok,
  input  logic          tok_pop
);
  import iee_pkg::*;

  localparam int QD = 4;

  tok_t       queue [QD];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 3'(QD));
  assign tok_valid = (count != 3'd0);
  assign tok       = queue[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = tok_pop && tok_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= classify(char_code);
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(do_push) - 3'(do_pop);
    end
  end

endmodule

>>> hdl/iee_div.sv
// ----------------------------------------------------------------------------
// iee_div: unsigned restoring divider
// Produces one quotient bit per cycle; the quotient holds after done.
// ----------------------------------------------------------------------------
module iee_div #(
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [32:0]   rem;
  logic [31:0]   dvs;
  logic [CW-1:0] cnt;
  logic [32:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem[31:0], quotient[DW-1]};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quotient <= {quotient[DW-2:0], ge};
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/iee_engine.sv
// ----------------------------------------------------------------------------
// iee_engine: two-stack execution engine
// Builds numbers, keeps the value and operator stacks, reduces operators
// with precedence and drives the registered result.
// ----------------------------------------------------------------------------
module iee_engine #(
  parameter int VALUE_STACK_DEPTH    = iee_pkg::VALUE_STACK_DEPTH_DEF,
  parameter int OPERATOR_STACK_DEPTH = iee_pkg::OPERATOR_STACK_DEPTH_DEF,
  parameter int FRACTION_BITS        = iee_pkg::FRACTION_BITS_DEF,
  parameter int MAX_FRACTION_DIGITS  = iee_pkg::MAX_FRACTION_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  input  iee_pkg::tok_t      tok,
  output logic               tok_pop,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] result_value,
  output logic [2:0]         error_code
);
  import iee_pkg::*;

  localparam int VIW = $clog2(VALUE_STACK_DEPTH);
  localparam int VCW = $clog2(VALUE_STACK_DEPTH + 1);
  localparam int OIW = $clog2(OPERATOR_STACK_DEPTH);
  localparam int OCW = $clog2(OPERATOR_STACK_DEPTH + 1);
  localparam int DW  = 32 + FRACTION_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_FIN_START, S_FIN_WAIT, S_FIN_PUSH, S_DISPATCH, S_R_LOOK,
    S_R_CHECK, S_EXEC, S_MUL2, S_DIV_WAIT, S_WRITE, S_EMIT
  } state_t;

  state_t state;

  logic signed [31:0] vmem [VALUE_STACK_DEPTH];
  logic [2:0]         omem [OPERATOR_STACK_DEPTH];
  logic signed [31:0] vrd_a;
  logic signed [31:0] vrd_b;
  logic [2:0]         ord;
  logic [VCW-1:0]     vcnt;
  logic [OCW-1:0]     ocnt;
  logic [VCW-1:0]     vcnt_m1;
  logic [VCW-1:0]     vcnt_m2;
  logic [OCW-1:0]     ocnt_m1;

  logic [31:0]           int_part;
  logic [FRAC_ACC_W-1:0] frac_part;
  logic [2:0]            frac_cnt;
  logic                  pending;
  logic                  point_seen;
  logic [2:0]            sticky;

  tok_kind_t          cur_kind;
  logic               muldiv_mode;
  op_code_t           cur_op;
  logic signed [31:0] res;
  logic [63:0]        prod;
  logic               neg;

  logic               out_valid;

  // Divider interface
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [31:0]   div_divisor;
  logic          div_busy;
  logic          div_done;
  logic [DW-1:0] div_q;

  // Combinational helpers
  logic [35:0]           int_n;
  logic [FRAC_ACC_W+3:0] frac_n;
  logic [DW:0]           num_v;
  logic                  num_sat;
  logic signed [31:0]    num_val;
  op_code_t              top_op;
  logic                  do_reduce;
  logic [32:0]           addsub;
  logic                  addsub_sat;
  logic signed [31:0]    addsub_val;
  sat_res_t              mul_res;
  sat_res_t              div_res;
  logic [2:0]            flag_code;
  logic                  v_we;
  logic [VIW-1:0]        v_wa;
  logic signed [31:0]    v_wd;
  logic                  o_we;
  op_code_t              push_code;
  logic                  emit_go;
  logic [2:0]            emit_err;
  logic [2:0]            emit_flag;

  assign vcnt_m1 = vcnt - VCW'(1);
  assign vcnt_m2 = vcnt - VCW'(2);
  assign ocnt_m1 = ocnt - OCW'(1);
  assign empty   = !out_valid;
  assign tok_pop = (state == S_IDLE) && tok_valid;

  iee_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Stack memories: one write port, registered reads of the top entries.
  always_ff @(posedge clk) begin
    vrd_b <= vmem[vcnt_m1[VIW-1:0]];
    vrd_a <= vmem[vcnt_m2[VIW-1:0]];
    ord   <= omem[ocnt_m1[OIW-1:0]];
    if (v_we) vmem[v_wa] <= v_wd;
    if (o_we) omem[ocnt[OIW-1:0]] <= push_code;
  end

  always_comb begin
    int_n  = ({4'd0, int_part} << 3) + ({4'd0, int_part} << 1) + 36'(tok.digit);
    frac_n = ({4'd0, frac_part} << 3) + ({4'd0, frac_part} << 1)
             + (FRAC_ACC_W+4)'(tok.digit);

    num_v   = ((DW+1)'(int_part) << FRACTION_BITS)
              + ((frac_cnt == 3'd0) ? '0 : (DW+1)'(div_q));
    num_sat = (num_v > (DW+1)'(32'h7FFF_FFFF));
    num_val = num_sat ? 32'sh7FFF_FFFF : num_v[31:0];

    top_op    = (ocnt == OCW'(1)) ? OP_PAREN : op_code_t'(ord);
    do_reduce = muldiv_mode ? (top_op == OP_MUL || top_op == OP_DIV)
                            : (top_op != OP_PAREN);

    addsub = (cur_op == OP_SUB) ? ({vrd_a[31], vrd_a} - {vrd_b[31], vrd_b})
                                : ({vrd_a[31], vrd_a} + {vrd_b[31], vrd_b});
    addsub_sat = (addsub[32] != addsub[31]);
    addsub_val = addsub_sat ? (addsub[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                            : addsub[31:0];
    mul_res = from_mag(neg, prod >> FRACTION_BITS);
    div_res = from_mag(neg, 64'(div_q));

    push_code = OP_PAREN;
    case (cur_kind)
      TK_ADD: push_code = OP_ADD;
      TK_SUB: push_code = OP_SUB;
      TK_MUL: push_code = OP_MUL;
      TK_DIV: push_code = OP_DIV;
      default: push_code = OP_PAREN;
    endcase

    div_start    = 1'b0;
    div_dividend = (DW'(mag32(vrd_a)) << FRACTION_BITS);
    div_divisor  = mag32(vrd_b);
    if (state == S_FIN_START) begin
      div_dividend = (DW'(frac_part) << FRACTION_BITS) + DW'(pow10(frac_cnt) >> 1);
      div_divisor  = 32'(pow10(frac_cnt));
      div_start    = (frac_cnt != 3'd0);
    end else if (state == S_EXEC) begin
      div_start = (cur_op == OP_DIV) && (vrd_b != 32'sd0);
    end

    v_we = 1'b0;
    v_wa = vcnt[VIW-1:0];
    v_wd = num_val;
    if (state == S_FIN_PUSH) begin
      v_we = (vcnt < VCW'(VALUE_STACK_DEPTH));
    end else if (state == S_WRITE) begin
      v_we = 1'b1;
      v_wa = vcnt_m2[VIW-1:0];
      v_wd = res;
    end

    o_we = 1'b0;
    if ((state == S_DISPATCH && cur_kind == TK_LPAREN) ||
        (state == S_R_CHECK && !do_reduce &&
         (cur_kind == TK_ADD || cur_kind == TK_SUB ||
          cur_kind == TK_MUL || cur_kind == TK_DIV))) begin
      o_we = (ocnt < OCW'(OPERATOR_STACK_DEPTH));
    end

    flag_code = ERR_NONE;
    unique case (state)
      S_FIN_PUSH: begin
        if (num_sat) flag_code = ERR_SAT;
        else if (!v_we) flag_code = ERR_OVERFLOW;
      end
      S_DISPATCH: begin
        if (cur_kind == TK_LPAREN && !o_we) flag_code = ERR_OVERFLOW;
      end
      S_R_CHECK: begin
        if (do_reduce) begin
          if (vcnt < VCW'(2)) flag_code = ERR_MALFORMED;
        end else if (cur_kind == TK_RPAREN) begin
          if (ocnt == OCW'(1)) flag_code = ERR_MALFORMED;
        end else if (cur_kind == TK_EQUALS) begin
          if (ocnt != OCW'(1)) flag_code = ERR_MALFORMED;
        end else if (cur_kind != TK_OTHER && !o_we) begin
          flag_code = ERR_OVERFLOW;
        end
      end
      S_EXEC: begin
        if ((cur_op == OP_ADD || cur_op == OP_SUB) && addsub_sat) flag_code = ERR_SAT;
        else if (cur_op == OP_DIV && vrd_b == 32'sd0) flag_code = ERR_DIV0;
      end
      S_MUL2:     if (mul_res.sat) flag_code = ERR_SAT;
      S_DIV_WAIT: if (div_done && div_res.sat) flag_code = ERR_SAT;
      default:    flag_code = ERR_NONE;
    endcase

    emit_go   = (state == S_EMIT) && (!out_valid || pop);
    emit_flag = (vcnt != VCW'(1)) ? ERR_MALFORMED : ERR_NONE;
    emit_err  = (sticky != ERR_NONE) ? sticky : emit_flag;
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      result_value <= (vcnt == '0) ? 32'sd0 : vrd_b;
      error_code   <= emit_err;
    end
    if (rst) begin
      state       <= S_IDLE;
      vcnt        <= '0;
      ocnt        <= OCW'(1);
      int_part    <= '0;
      frac_part   <= '0;
      frac_cnt    <= '0;
      pending     <= 1'b0;
      point_seen  <= 1'b0;
      sticky      <= ERR_NONE;
      out_valid   <= 1'b0;
      cur_kind    <= TK_OTHER;
      muldiv_mode <= 1'b0;
      cur_op      <= OP_PAREN;
      res         <= '0;
      prod        <= '0;
      neg         <= 1'b0;
    end else begin
      if (pop && out_valid && !emit_go) out_valid <= 1'b0;
      if (sticky == ERR_NONE && flag_code != ERR_NONE) sticky <= flag_code;
      if (v_we && state == S_FIN_PUSH) vcnt <= vcnt + VCW'(1);
      if (o_we) ocnt <= ocnt + OCW'(1);

      unique case (state)
        S_IDLE: begin
          if (tok_valid) begin
            cur_kind    <= tok.kind;
            muldiv_mode <= (tok.kind == TK_MUL || tok.kind == TK_DIV);
            if (tok.kind == TK_DIGIT) begin
              pending <= 1'b1;
              if (point_seen) begin
                if (frac_cnt < 3'(MAX_FRACTION_DIGITS)) begin
                  frac_part <= frac_n[FRAC_ACC_W-1:0];
                  frac_cnt  <= frac_cnt + 3'd1;
                end
              end else begin
                int_part <= (int_n[35:32] != 4'd0) ? 32'hFFFF_FFFF : int_n[31:0];
              end
            end else if (tok.kind == TK_POINT) begin
              pending    <= 1'b1;
              point_seen <= 1'b1;
            end else begin
              state <= pending ? S_FIN_START : S_DISPATCH;
            end
          end
        end
        S_FIN_START: state <= (frac_cnt != 3'd0) ? S_FIN_WAIT : S_FIN_PUSH;
        S_FIN_WAIT:  if (div_done) state <= S_FIN_PUSH;
        S_FIN_PUSH: begin
          int_part   <= '0;
          frac_part  <= '0;
          frac_cnt   <= '0;
          pending    <= 1'b0;
          point_seen <= 1'b0;
          state      <= S_DISPATCH;
        end
        S_DISPATCH: begin
          case (cur_kind)
            TK_ADD, TK_SUB, TK_MUL, TK_DIV, TK_RPAREN, TK_EQUALS: state <= S_R_LOOK;
            default: state <= S_IDLE;
          endcase
        end
        S_R_LOOK: state <= S_R_CHECK;
        S_R_CHECK: begin
          if (do_reduce) begin
            ocnt   <= ocnt_m1;
            cur_op <= top_op;
            state  <= (vcnt < VCW'(2)) ? S_R_LOOK : S_EXEC;
          end else begin
            case (cur_kind)
              TK_RPAREN: begin
                if (ocnt != OCW'(1)) ocnt <= ocnt_m1;
                state <= S_IDLE;
              end
              TK_EQUALS: begin
                if (ocnt != OCW'(1)) begin
                  ocnt  <= ocnt_m1;
                  state <= S_R_LOOK;
                end else begin
                  state <= S_EMIT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_EXEC: begin
          neg <= vrd_a[31] ^ vrd_b[31];
          unique case (cur_op)
            OP_MUL: begin
              prod  <= mag32(vrd_a) * mag32(vrd_b);
              state <= S_MUL2;
            end
            OP_DIV: begin
              res   <= '0;
              state <= (vrd_b == 32'sd0) ? S_WRITE : S_DIV_WAIT;
            end
            default: begin
              res   <= addsub_val;
              state <= S_WRITE;
            end
          endcase
        end
        S_MUL2: begin
          res   <= mul_res.value;
          state <= S_WRITE;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            res   <= div_res.value;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          vcnt  <= vcnt_m1;
          state <= S_R_LOOK;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid  <= 1'b1;
            vcnt       <= '0;
            ocnt       <= OCW'(1);
            int_part   <= '0;
            frac_part  <= '0;
            frac_cnt   <= '0;
            pending    <= 1'b0;
            point_seen <= 1'b0;
            sticky     <= ERR_NONE;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The sentinel entry is never popped.
  a_sentinel_kept: assert property (@(posedge clk) disable iff (rst) ocnt != '0)
    else $error("operator stack lost its sentinel");

  a_vcnt_range: assert property (@(posedge clk) disable iff (rst)
    vcnt <= VCW'(VALUE_STACK_DEPTH))
    else $error("value count beyond stack depth");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_write_pops: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |=> vcnt == $past(vcnt) - VCW'(1))
    else $error("reduction did not pop one value");

endmodule

>>> hdl/infix_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core: character-stream arithmetic evaluator
// Evaluates + - * / with parentheses over signed fixed-point numbers and
// returns one result with an error code at each '='.
// ----------------------------------------------------------------------------
// Characters enter through a push/full queue and results leave through an
// empty/pop queue. The engine takes a digit or a point in its idle state;
// ending a number that has fraction digits runs the shared restoring divider.
// Each operator reduction walks the operator stack one entry at a time:
// look, check, execute, a second multiply step or a divider wait, and the
// stack write, with the stack reads registered. A four entry token queue
// sits between intake and engine, so characters keep coming in while a long
// reduction or division runs, and the result register frees the engine
// while a finished result waits to be popped.
// The error code reports the first fault of the expression: 1 divide by
// zero, 2 stack overflow, 3 malformed expression, 4 saturation.
module infix_expression_evaluator_core #(
  parameter int VALUE_STACK_DEPTH    = iee_pkg::VALUE_STACK_DEPTH_DEF,
  parameter int OPERATOR_STACK_DEPTH = iee_pkg::OPERATOR_STACK_DEPTH_DEF,
  parameter int FRACTION_BITS        = iee_pkg::FRACTION_BITS_DEF,
  parameter int MAX_FRACTION_DIGITS  = iee_pkg::MAX_FRACTION_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_code,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] result_value,
  output logic [2:0]         error_code
);
  import iee_pkg::*;

  // Token handoff between intake and engine.
  logic tok_valid;
  tok_t tok;
  logic tok_pop;

  iee_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop)
  );

  iee_engine #(
    .VALUE_STACK_DEPTH    (VALUE_STACK_DEPTH),
    .OPERATOR_STACK_DEPTH (OPERATOR_STACK_DEPTH),
    .FRACTION_BITS        (FRACTION_BITS),
    .MAX_FRACTION_DIGITS  (MAX_FRACTION_DIGITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .tok_valid    (tok_valid),
    .tok          (tok),
    .tok_pop      (tok_pop),
    .empty        (empty),
    .pop          (pop),
    .result_value (result_value),
    .error_code   (error_code)
  );

endmodule
